>>> rtl/rgb_pwm_color_fade_core_defines.svh
// ----------------------------------------------------------------------------
// RGB PWM color fade core - assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RGB_PWM_COLOR_FADE_CORE_DEFINES_SVH
`define RGB_PWM_COLOR_FADE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RPCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPCF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPCF_ASSERT(label, prop, msg)
`define RPCF_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> rtl/rpcf_pkg.sv
// ----------------------------------------------------------------------------
// RGB PWM color fade package
// Widths, codes, reset values and transfer structs shared by the core.
// ----------------------------------------------------------------------------
package rpcf_pkg;

  localparam int unsigned DUTY_FULL_DEF = 100;

  localparam int unsigned GEAR_W   = 4;
  localparam int unsigned PHASE_W  = 7;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned PERIOD_W = 16;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd500;

  localparam int unsigned PCT_20   = 20;
  localparam int unsigned PCT_50   = 50;
  localparam int unsigned PCT_70   = 70;
  localparam int unsigned PCT_BASE = 100;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_GEAR = 1'b1;

  localparam logic [GEAR_W-1:0] GEAR_OFF     = 4'd0;
  localparam logic [GEAR_W-1:0] GEAR_WHITE   = 4'd1;
  localparam logic [GEAR_W-1:0] GEAR_RED     = 4'd2;
  localparam logic [GEAR_W-1:0] GEAR_GREEN   = 4'd3;
  localparam logic [GEAR_W-1:0] GEAR_BLUE    = 4'd4;
  localparam logic [GEAR_W-1:0] GEAR_YELLOW  = 4'd5;
  localparam logic [GEAR_W-1:0] GEAR_MAGENTA = 4'd6;
  localparam logic [GEAR_W-1:0] GEAR_CYAN    = 4'd7;
  localparam logic [GEAR_W-1:0] GEAR_ORANGE  = 4'd8;
  localparam logic [GEAR_W-1:0] GEAR_FADE    = 4'd9;

  typedef struct packed {
    logic               req_type;
    logic [GEAR_W-1:0]  gear;
    logic [PHASE_W-1:0] pwm_phase;
  } item_t;

  typedef struct packed {
    logic               red_on;
    logic               green_on;
    logic               blue_on;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic               fading;
  } result_t;

endpackage

>>> rtl/rpcf_in_reg.sv
// ----------------------------------------------------------------------------
// RGB PWM color fade input register
// Holds one accepted request until the engine consumes it.
// ----------------------------------------------------------------------------
module rpcf_in_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [rpcf_pkg::GEAR_W-1:0]       in_gear,
  input  logic [rpcf_pkg::PHASE_W-1:0]      in_pwm_phase,
  input  logic                              take,
  output logic                              item_valid,
  output rpcf_pkg::item_t                   item
);

  logic            valid_r;
  logic            valid_nxt;
  rpcf_pkg::item_t item_r;
  logic            accept;

  assign in_ready   = !valid_r || take;
  assign accept     = in_valid && in_ready;
  assign valid_nxt  = accept || (valid_r && !take);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.req_type  <= in_req_type;
      item_r.gear      <= in_gear;
      item_r.pwm_phase <= in_pwm_phase;
    end
  end

endmodule

>>> rtl/rpcf_engine.sv
// ----------------------------------------------------------------------------
// RGB PWM color fade engine
// Duty state, gear presets, step prescaler and fade sequencer.
// ----------------------------------------------------------------------------
`include "rgb_pwm_color_fade_core_defines.svh"

module rpcf_engine #(
  parameter int unsigned DUTY_FULL = rpcf_pkg::DUTY_FULL_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  rpcf_pkg::item_t                    item,
  input  logic [rpcf_pkg::PERIOD_W-1:0]      step_period,
  output rpcf_pkg::result_t                  result
);

  localparam int unsigned DW = $clog2(DUTY_FULL + 1);
  localparam int unsigned CW = (DW > rpcf_pkg::PHASE_W) ? DW : rpcf_pkg::PHASE_W;
  localparam logic [DW-1:0] Full  = DW'(DUTY_FULL);
  localparam logic [DW-1:0] Duty20 =
    DW'((rpcf_pkg::PCT_20 * DUTY_FULL) / rpcf_pkg::PCT_BASE);
  localparam logic [DW-1:0] Duty50 =
    DW'((rpcf_pkg::PCT_50 * DUTY_FULL) / rpcf_pkg::PCT_BASE);
  localparam logic [DW-1:0] Duty70 =
    DW'((rpcf_pkg::PCT_70 * DUTY_FULL) / rpcf_pkg::PCT_BASE);

  logic [DW-1:0]                 red_duty_r, green_duty_r, blue_duty_r;
  logic [DW-1:0]                 red_duty_nxt, green_duty_nxt, blue_duty_nxt;
  logic                          fade_mode_r, fade_mode_nxt;
  logic                          red_flag_r, green_flag_r, blue_flag_r;
  logic                          red_flag_nxt, green_flag_nxt, blue_flag_nxt;
  logic [rpcf_pkg::PERIOD_W-1:0] step_prescaler_r, step_prescaler_nxt;

  logic [DW-1:0]                 red_inc, red_dec, green_inc, green_dec;
  logic [DW-1:0]                 blue_inc, blue_dec;
  logic                          all_full;
  logic [DW-1:0]                 st_red, st_green, st_blue;
  logic                          st_rf, st_gf, st_bf;
  logic [rpcf_pkg::PERIOD_W-1:0] presc_inc;

  assign red_inc   = (red_duty_r < Full) ? red_duty_r + DW'(1) : red_duty_r;
  assign green_inc = (green_duty_r < Full) ? green_duty_r + DW'(1) : green_duty_r;
  assign blue_inc  = (blue_duty_r < Full) ? blue_duty_r + DW'(1) : blue_duty_r;
  assign red_dec   = (red_duty_r != '0) ? red_duty_r - DW'(1) : '0;
  assign green_dec = (green_duty_r != '0) ? green_duty_r - DW'(1) : '0;
  assign blue_dec  = (blue_duty_r != '0) ? blue_duty_r - DW'(1) : '0;
  assign all_full  = (red_duty_r == Full) && (green_duty_r == Full) &&
                     (blue_duty_r == Full);
  assign presc_inc = step_prescaler_r + rpcf_pkg::PERIOD_W'(1);

  // one fade sequencer step from the current state
  always_comb begin
    st_red   = red_duty_r;
    st_green = green_duty_r;
    st_blue  = blue_duty_r;
    st_rf    = red_flag_r || all_full;
    st_gf    = green_flag_r || all_full;
    st_bf    = blue_flag_r || all_full;
    if (st_rf && st_gf && st_bf) begin
      if (red_duty_r != '0) begin
        st_red   = red_dec;
        st_green = green_dec;
      end else begin
        st_rf = 1'b0;
        st_gf = 1'b0;
        st_bf = 1'b0;
      end
    end else if (!st_rf) begin
      st_red  = red_inc;
      st_blue = blue_dec;
      if (red_inc == Full) begin
        st_rf = 1'b1;
        st_gf = 1'b0;
      end
    end else if (!st_gf) begin
      st_red   = red_dec;
      st_green = green_inc;
      if (green_inc == Full) begin
        st_gf = 1'b1;
      end
    end else begin
      st_green = green_dec;
      st_blue  = blue_inc;
      if (blue_inc == Full) begin
        st_rf = 1'b0;
        st_gf = 1'b0;
      end
    end
  end

  always_comb begin
    red_duty_nxt       = red_duty_r;
    green_duty_nxt     = green_duty_r;
    blue_duty_nxt      = blue_duty_r;
    fade_mode_nxt      = fade_mode_r;
    red_flag_nxt       = red_flag_r;
    green_flag_nxt     = green_flag_r;
    blue_flag_nxt      = blue_flag_r;
    step_prescaler_nxt = step_prescaler_r;
    if (fire) begin
      if (item.req_type == rpcf_pkg::REQ_GEAR) begin
        if (item.gear inside {[rpcf_pkg::GEAR_OFF:rpcf_pkg::GEAR_ORANGE]}) begin
          fade_mode_nxt      = 1'b0;
          step_prescaler_nxt = '0;
        end
        case (item.gear)
          rpcf_pkg::GEAR_OFF: begin
            red_duty_nxt = '0;   green_duty_nxt = '0;     blue_duty_nxt = '0;
          end
          rpcf_pkg::GEAR_WHITE: begin
            red_duty_nxt = Full; green_duty_nxt = Full;   blue_duty_nxt = Full;
          end
          rpcf_pkg::GEAR_RED: begin
            red_duty_nxt = Full; green_duty_nxt = '0;     blue_duty_nxt = '0;
          end
          rpcf_pkg::GEAR_GREEN: begin
            red_duty_nxt = '0;   green_duty_nxt = Full;   blue_duty_nxt = '0;
          end
          rpcf_pkg::GEAR_BLUE: begin
            red_duty_nxt = '0;   green_duty_nxt = '0;     blue_duty_nxt = Full;
          end
          rpcf_pkg::GEAR_YELLOW: begin
            red_duty_nxt = Full; green_duty_nxt = Full;   blue_duty_nxt = '0;
          end
          rpcf_pkg::GEAR_MAGENTA: begin
            red_duty_nxt = Full; green_duty_nxt = '0;     blue_duty_nxt = Full;
          end
          rpcf_pkg::GEAR_CYAN: begin
            red_duty_nxt = '0;   green_duty_nxt = Full;   blue_duty_nxt = Full;
          end
          rpcf_pkg::GEAR_ORANGE: begin
            red_duty_nxt = Full; green_duty_nxt = Duty70; blue_duty_nxt = '0;
          end
          rpcf_pkg::GEAR_FADE: begin
            if (!fade_mode_r) begin
              red_duty_nxt   = Duty20;
              green_duty_nxt = '0;
              blue_duty_nxt  = Duty50;
            end
            fade_mode_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end else if (!fade_mode_r) begin
        step_prescaler_nxt = '0;
      end else if (presc_inc >= step_period) begin
        step_prescaler_nxt = '0;
        red_duty_nxt       = st_red;
        green_duty_nxt     = st_green;
        blue_duty_nxt      = st_blue;
        red_flag_nxt       = st_rf;
        green_flag_nxt     = st_gf;
        blue_flag_nxt      = st_bf;
      end else begin
        step_prescaler_nxt = presc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_duty_r       <= '0;
      green_duty_r     <= '0;
      blue_duty_r      <= '0;
      fade_mode_r      <= 1'b0;
      red_flag_r       <= 1'b0;
      green_flag_r     <= 1'b0;
      blue_flag_r      <= 1'b0;
      step_prescaler_r <= '0;
    end else begin
      red_duty_r       <= red_duty_nxt;
      green_duty_r     <= green_duty_nxt;
      blue_duty_r      <= blue_duty_nxt;
      fade_mode_r      <= fade_mode_nxt;
      red_flag_r       <= red_flag_nxt;
      green_flag_r     <= green_flag_nxt;
      blue_flag_r      <= blue_flag_nxt;
      step_prescaler_r <= step_prescaler_nxt;
    end
  end

  assign result.red_on      = CW'(item.pwm_phase) < CW'(red_duty_nxt);
  assign result.green_on    = CW'(item.pwm_phase) < CW'(green_duty_nxt);
  assign result.blue_on     = CW'(item.pwm_phase) < CW'(blue_duty_nxt);
  assign result.red_level   = rpcf_pkg::LEVEL_W'(red_duty_nxt);
  assign result.green_level = rpcf_pkg::LEVEL_W'(green_duty_nxt);
  assign result.blue_level  = rpcf_pkg::LEVEL_W'(blue_duty_nxt);
  assign result.fading      = fade_mode_nxt;

  `RPCF_ASSERT(a_duty_range, (red_duty_r <= Full) && (green_duty_r <= Full) && (blue_duty_r <= Full), "duty above full scale")
  `RPCF_ASSERT(a_presc_idle, !fade_mode_r |-> (step_prescaler_r == '0), "prescaler running outside fade mode")
  `RPCF_ASSERT(a_preset_exit, (fire && (item.req_type == rpcf_pkg::REQ_GEAR) && (item.gear <= rpcf_pkg::GEAR_ORANGE)) |=> !fade_mode_r, "preset gear did not leave fade mode")
  `RPCF_ASSERT_RST(a_reset_state, !rst_n |=> (!fade_mode_r && (red_duty_r == '0) && (step_prescaler_r == '0)), "state not cleared by reset")

endmodule

>>> rtl/rpcf_out_reg.sv
// ----------------------------------------------------------------------------
// RGB PWM color fade output register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module rpcf_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  rpcf_pkg::result_t             result,
  output logic                          space,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_red_on,
  output logic                          out_green_on,
  output logic                          out_blue_on,
  output logic [rpcf_pkg::LEVEL_W-1:0]  out_red_level,
  output logic [rpcf_pkg::LEVEL_W-1:0]  out_green_level,
  output logic [rpcf_pkg::LEVEL_W-1:0]  out_blue_level,
  output logic                          out_fading
);

  logic              valid_r;
  logic              valid_nxt;
  rpcf_pkg::result_t result_r;

  assign space     = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid       = valid_r;
  assign out_red_on      = result_r.red_on;
  assign out_green_on    = result_r.green_on;
  assign out_blue_on     = result_r.blue_on;
  assign out_red_level   = result_r.red_level;
  assign out_green_level = result_r.green_level;
  assign out_blue_level  = result_r.blue_level;
  assign out_fading      = result_r.fading;

endmodule

>>> rtl/rgb_pwm_color_fade_core.sv
// ----------------------------------------------------------------------------
// RGB PWM color fade core
// Three-channel LED PWM driver with color presets and a fade sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transfer; req_type 0 is a PWM timer tick, 1 a
//           gear selection (0..8 presets, 9 fade mode, above 9 ignored).
//   out_* : one result per request: the three LED enables for pwm_phase
//           and the red, green and blue levels after the update, plus fading.
//   cfg_* : step_period, ticks between fade steps; write only while idle.
// Pipeline: input register, then engine update into the output register.
// Throughput: one request per cycle while out_ready is high; the duty and
//   sequencer state is a single register loop updated in the cycle a
//   request leaves the input register.
// Reset: duties zero, fade mode off, prescaler zero, step_period 500.
// Stall: while out_ready is low the result holds; the input register still
//   takes one more request, after which in_ready drops.
// ----------------------------------------------------------------------------
module rgb_pwm_color_fade_core #(
  parameter int unsigned DUTY_FULL = rpcf_pkg::DUTY_FULL_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [rpcf_pkg::GEAR_W-1:0]        in_gear,
  input  logic [rpcf_pkg::PHASE_W-1:0]       in_pwm_phase,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_red_on,
  output logic                               out_green_on,
  output logic                               out_blue_on,
  output logic [rpcf_pkg::LEVEL_W-1:0]       out_red_level,
  output logic [rpcf_pkg::LEVEL_W-1:0]       out_green_level,
  output logic [rpcf_pkg::LEVEL_W-1:0]       out_blue_level,
  output logic                               out_fading,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rpcf_pkg::PERIOD_W-1:0]      cfg_step_period
);

  logic [rpcf_pkg::PERIOD_W-1:0] step_period_r;
  logic                          item_valid;
  rpcf_pkg::item_t               item;
  rpcf_pkg::result_t             result;
  logic                          space;
  logic                          fire;

  assign cfg_ready = 1'b1;
  assign fire      = item_valid && space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r <= rpcf_pkg::STEP_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      step_period_r <= cfg_step_period;
    end
  end

  rpcf_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_gear      (in_gear),
    .in_pwm_phase (in_pwm_phase),
    .take         (space),
    .item_valid   (item_valid),
    .item         (item)
  );

  rpcf_engine #(
    .DUTY_FULL (DUTY_FULL)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (item),
    .step_period (step_period_r),
    .result      (result)
  );

  rpcf_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (fire),
    .result          (result),
    .space           (space),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red_on      (out_red_on),
    .out_green_on    (out_green_on),
    .out_blue_on     (out_blue_on),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_fading      (out_fading)
  );

endmodule
